// ===== rtl/core/lrsd_pkg.sv =====
// ----------------------------------------------------------------------------
// lrsd_pkg: shared types and constants of the LPP record stream decoder
// Type codes, tags, divisor codes, end status codes and the record
// descriptor that the type decoder hands to the core.
// ----------------------------------------------------------------------------
package lrsd_pkg;

    // field widths of the byte and result words
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned TAG_W    = 2;
    localparam int unsigned INDEX_W  = 8;
    localparam int unsigned RAW_W    = 17;
    localparam int unsigned SCALE_W  = 2;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned LEN_W    = 4;

    // record type codes on the wire
    localparam logic [BYTE_W-1:0] TYPE_DIGITAL     = 8'd0;
    localparam logic [BYTE_W-1:0] TYPE_ANALOG      = 8'd2;
    localparam logic [BYTE_W-1:0] TYPE_LUMINOSITY  = 8'd101;
    localparam logic [BYTE_W-1:0] TYPE_TEMPERATURE = 8'd103;
    localparam logic [BYTE_W-1:0] TYPE_HUMIDITY    = 8'd104;
    localparam logic [BYTE_W-1:0] TYPE_ACCEL       = 8'd113;
    localparam logic [BYTE_W-1:0] TYPE_PRESSURE    = 8'd115;
    localparam logic [BYTE_W-1:0] TYPE_GPS         = 8'd136;

    // data lengths in bytes
    localparam logic [LEN_W-1:0] LEN_BYTE  = 4'd1;
    localparam logic [LEN_W-1:0] LEN_WORD  = 4'd2;
    localparam logic [LEN_W-1:0] LEN_ACCEL = 4'd6;
    localparam logic [LEN_W-1:0] LEN_GPS   = 4'd9;

    // value tags
    localparam logic [TAG_W-1:0] TAG_TEMP  = 2'd0;
    localparam logic [TAG_W-1:0] TAG_PRESS = 2'd1;
    localparam logic [TAG_W-1:0] TAG_DEFL  = 2'd2;
    localparam logic [TAG_W-1:0] TAG_OTHER = 2'd3;

    // divisor codes: 1, 2, 10, 100
    localparam logic [SCALE_W-1:0] SCALE_DIV1   = 2'd0;
    localparam logic [SCALE_W-1:0] SCALE_DIV2   = 2'd1;
    localparam logic [SCALE_W-1:0] SCALE_DIV10  = 2'd2;
    localparam logic [SCALE_W-1:0] SCALE_DIV100 = 2'd3;

    // end of payload status
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TRUNCATED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNKNOWN   = 2'd2;

    // what a type byte says about the record that follows
    typedef struct packed {
        logic                known;
        logic                emits;
        logic                is_signed;
        logic [TAG_W-1:0]    tag;
        logic [SCALE_W-1:0]  scale;
        logic [LEN_W-1:0]    len;
    } kind_info_t;

endpackage

// ===== rtl/core/lrsd_byte_if.sv =====
// ----------------------------------------------------------------------------
// lrsd_byte_if: payload byte channel
// Valid/ready channel that carries one payload byte and its last flag.
// ----------------------------------------------------------------------------
interface lrsd_byte_if;
    import lrsd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source (
        output valid,
        input  ready,
        output data_byte,
        output last_byte
    );

    modport sink (
        input  valid,
        output ready,
        input  data_byte,
        input  last_byte
    );

endinterface

// ===== rtl/core/lrsd_result_if.sv =====
// ----------------------------------------------------------------------------
// lrsd_result_if: decoded result channel
// Valid/ready channel that carries one decoded value and/or end status word.
// ----------------------------------------------------------------------------
interface lrsd_result_if;
    import lrsd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       value_valid;
    logic [TAG_W-1:0]           tag;
    logic [INDEX_W-1:0]         tag_index;
    logic signed [RAW_W-1:0]    raw_value;
    logic [SCALE_W-1:0]         scale_code;
    logic [BYTE_W-1:0]          channel_number;
    logic                       end_of_payload;
    logic [STATUS_W-1:0]        end_status;

    modport source (
        output valid,
        input  ready,
        output value_valid,
        output tag,
        output tag_index,
        output raw_value,
        output scale_code,
        output channel_number,
        output end_of_payload,
        output end_status
    );

    modport sink (
        input  valid,
        output ready,
        input  value_valid,
        input  tag,
        input  tag_index,
        input  raw_value,
        input  scale_code,
        input  channel_number,
        input  end_of_payload,
        input  end_status
    );

endinterface

// ===== rtl/core/lrsd_type_decode.sv =====
// ----------------------------------------------------------------------------
// lrsd_type_decode: record type lookup
// Map a record type byte to its data length, tag, divisor and signedness.
// ----------------------------------------------------------------------------
module lrsd_type_decode (
    input  logic [lrsd_pkg::BYTE_W-1:0] type_byte,
    output lrsd_pkg::kind_info_t        info
);
    import lrsd_pkg::*;

    // look up the record descriptor; unknown codes come back not known
    always_comb
    begin
        info = '0;
        case (type_byte)
            TYPE_DIGITAL:
            begin
                info = '{known: 1'b1, emits: 1'b1, is_signed: 1'b0,
                         tag: TAG_OTHER, scale: SCALE_DIV1, len: LEN_BYTE};
            end
            TYPE_ANALOG:
            begin
                info = '{known: 1'b1, emits: 1'b1, is_signed: 1'b1,
                         tag: TAG_DEFL, scale: SCALE_DIV100, len: LEN_WORD};
            end
            TYPE_LUMINOSITY:
            begin
                info = '{known: 1'b1, emits: 1'b1, is_signed: 1'b0,
                         tag: TAG_OTHER, scale: SCALE_DIV1, len: LEN_WORD};
            end
            TYPE_TEMPERATURE:
            begin
                info = '{known: 1'b1, emits: 1'b1, is_signed: 1'b1,
                         tag: TAG_TEMP, scale: SCALE_DIV10, len: LEN_WORD};
            end
            TYPE_HUMIDITY:
            begin
                info = '{known: 1'b1, emits: 1'b1, is_signed: 1'b0,
                         tag: TAG_OTHER, scale: SCALE_DIV2, len: LEN_BYTE};
            end
            TYPE_PRESSURE:
            begin
                info = '{known: 1'b1, emits: 1'b1, is_signed: 1'b0,
                         tag: TAG_PRESS, scale: SCALE_DIV10, len: LEN_WORD};
            end
            TYPE_ACCEL:
            begin
                info = '{known: 1'b1, emits: 1'b0, is_signed: 1'b0,
                         tag: TAG_TEMP, scale: SCALE_DIV1, len: LEN_ACCEL};
            end
            TYPE_GPS:
            begin
                info = '{known: 1'b1, emits: 1'b0, is_signed: 1'b0,
                         tag: TAG_TEMP, scale: SCALE_DIV1, len: LEN_GPS};
            end
            default:
            begin
                info = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/lpp_record_stream_decoder_core.sv =====
// ----------------------------------------------------------------------------
// lpp_record_stream_decoder_core: LPP record stream decoder
// Parses channel/type/data records one payload byte at a time and emits
// decoded values and an end of payload status word.
// Output: a result appears on the output register in the cycle after the
// byte that causes it is accepted.
// Throughput: one byte per cycle; the output register takes a new word in
// the cycle its current word is taken, so a stall stops input only while full.
// Reset: rst_n clears the parser and the per-tag counts; all parser state
// also returns to its reset value after each byte flagged last.
// ----------------------------------------------------------------------------
module lpp_record_stream_decoder_core (
    input  logic          clk,
    input  logic          rst_n,
    lrsd_byte_if.sink     byte_ch,
    lrsd_result_if.source result_ch
);
    import lrsd_pkg::*;

    localparam logic [1:0] PH_CHAN = 2'd0;
    localparam logic [1:0] PH_TYPE = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    localparam int unsigned NUM_TAGS = 4;

    // parser state
    logic [1:0]         phase_reg, phase_next;
    kind_info_t         kind_reg, kind_next;
    logic [LEN_W-1:0]   left_reg, left_next;
    logic [BYTE_W-1:0]  high_reg, high_next;
    logic [BYTE_W-1:0]  chan_reg, chan_next;
    logic               stopped_reg, stopped_next;
    logic [INDEX_W-1:0] count_reg [NUM_TAGS];
    logic [INDEX_W-1:0] count_next [NUM_TAGS];

    // result register
    logic                    out_valid_reg, out_valid_next;
    logic                    value_valid_reg, value_valid_next;
    logic [TAG_W-1:0]        tag_reg, tag_next;
    logic [INDEX_W-1:0]      index_reg, index_next;
    logic signed [RAW_W-1:0] raw_reg, raw_next;
    logic [SCALE_W-1:0]      scale_reg, scale_next;
    logic [BYTE_W-1:0]       out_chan_reg, out_chan_next;
    logic                    eop_reg, eop_next;
    logic [STATUS_W-1:0]     status_reg, status_next;

    kind_info_t         type_info;
    logic               fire;
    logic               emit;
    logic [LEN_W-1:0]   left_dec;
    logic [15:0]        value16;

    lrsd_type_decode u_type_decode (
        .type_byte (byte_ch.data_byte),
        .info      (type_info)
    );

    // take a byte whenever the output register is free or being drained
    assign byte_ch.ready = !out_valid_reg || result_ch.ready;
    assign fire          = byte_ch.valid && byte_ch.ready;

    assign left_dec = (left_reg != '0) ? (left_reg - LEN_W'(1)) : left_reg;
    assign value16  = (kind_reg.len == LEN_WORD) ? {high_reg, byte_ch.data_byte}
                                                 : {8'd0, byte_ch.data_byte};

    // advance the parser and build the result word
    always_comb
    begin
        phase_next   = phase_reg;
        kind_next    = kind_reg;
        left_next    = left_reg;
        high_next    = high_reg;
        chan_next    = chan_reg;
        stopped_next = stopped_reg;
        for (int i = 0; i < NUM_TAGS; i++)
        begin
            count_next[i] = count_reg[i];
        end
        emit = 1'b0;

        value_valid_next = 1'b0;
        tag_next         = '0;
        index_next       = '0;
        raw_next         = '0;
        scale_next       = '0;
        out_chan_next    = '0;
        eop_next         = 1'b0;
        status_next      = STATUS_OK;

        if (fire && !stopped_reg)
        begin
            case (phase_reg)
                PH_CHAN:
                begin
                    chan_next  = byte_ch.data_byte;
                    phase_next = PH_TYPE;
                end
                PH_TYPE:
                begin
                    if (!type_info.known)
                    begin
                        stopped_next = 1'b1;
                        phase_next   = PH_CHAN;
                    end
                    else
                    begin
                        kind_next  = type_info;
                        left_next  = type_info.len;
                        phase_next = PH_DATA;
                    end
                end
                default:
                begin
                    if (left_reg == LEN_WORD)
                    begin
                        high_next = byte_ch.data_byte;
                    end
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        phase_next = PH_CHAN;
                        emit       = kind_reg.emits;
                    end
                end
            endcase
        end

        // fill in the value and bump the per-tag count
        if (emit)
        begin
            value_valid_next        = 1'b1;
            tag_next                = kind_reg.tag;
            index_next              = count_reg[kind_reg.tag];
            count_next[kind_reg.tag] = count_reg[kind_reg.tag] + INDEX_W'(1);
            raw_next      = {kind_reg.is_signed & value16[15], value16};
            scale_next    = kind_reg.scale;
            out_chan_next = chan_reg;
        end

        // close the payload: report status and drop all parser state
        if (fire && byte_ch.last_byte)
        begin
            eop_next = 1'b1;
            if (stopped_next)
            begin
                status_next = STATUS_UNKNOWN;
            end
            else if (phase_next != PH_CHAN)
            begin
                status_next = STATUS_TRUNCATED;
            end
            else
            begin
                status_next = STATUS_OK;
            end
            phase_next   = PH_CHAN;
            kind_next    = '0;
            left_next    = '0;
            high_next    = '0;
            chan_next    = '0;
            stopped_next = 1'b0;
            for (int i = 0; i < NUM_TAGS; i++)
            begin
                count_next[i] = '0;
            end
        end

        // hold the word until taken, load when a byte produces one
        if (fire && (emit || byte_ch.last_byte))
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control and parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_CHAN;
            kind_reg      <= '0;
            left_reg      <= '0;
            high_reg      <= '0;
            chan_reg      <= '0;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_TAGS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            phase_reg     <= phase_next;
            kind_reg      <= kind_next;
            left_reg      <= left_next;
            high_reg      <= high_next;
            chan_reg      <= chan_next;
            stopped_reg   <= stopped_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < NUM_TAGS; i++)
            begin
                count_reg[i] <= count_next[i];
            end
        end
    end

    // result payload; load only with a new word
    always_ff @(posedge clk)
    begin
        if (fire && (emit || byte_ch.last_byte))
        begin
            value_valid_reg <= value_valid_next;
            tag_reg         <= tag_next;
            index_reg       <= index_next;
            raw_reg         <= raw_next;
            scale_reg       <= scale_next;
            out_chan_reg    <= out_chan_next;
            eop_reg         <= eop_next;
            status_reg      <= status_next;
        end
    end

    assign result_ch.valid          = out_valid_reg;
    assign result_ch.value_valid    = value_valid_reg;
    assign result_ch.tag            = tag_reg;
    assign result_ch.tag_index      = index_reg;
    assign result_ch.raw_value      = raw_reg;
    assign result_ch.scale_code     = scale_reg;
    assign result_ch.channel_number = out_chan_reg;
    assign result_ch.end_of_payload = eop_reg;
    assign result_ch.end_status     = status_reg;

    // a payload end leaves the parser ready for a fresh channel byte
    a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire && byte_ch.last_byte |=> phase_reg == PH_CHAN && !stopped_reg
            && count_reg[0] == '0 && count_reg[3] == '0)
        else $error("parser state not cleared after last byte");

    // decoding stops only between records
    a_stopped_phase: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |-> phase_reg == PH_CHAN)
        else $error("stopped parser not in channel phase");

    // a data phase always has bytes outstanding
    a_data_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> left_reg != '0)
        else $error("data phase with no bytes left");

    // an error status only rides on the end of payload word
    a_status_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !eop_reg |-> status_reg == STATUS_OK && value_valid_reg)
        else $error("word without end flag carries a status or no value");

    // a word without a value carries zero fields
    a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !value_valid_reg |-> raw_reg == '0 && index_reg == '0
            && out_chan_reg == '0)
        else $error("word without value has nonzero fields");

endmodule

// ===== test/lrsd_decode_checker.sv =====
// ----------------------------------------------------------------------------
// lrsd_decode_checker: result checker of the LPP record stream decoder
// Watches the byte and result channels, runs its own record parser on every
// accepted byte word, queues the words the decoder must produce and compares
// each accepted result word with the oldest one, field by field.
// ----------------------------------------------------------------------------
module lrsd_decode_checker (
    input  logic    clk,
    input  logic    rst_n,
    lrsd_byte_if    byte_mon,
    lrsd_result_if  result_mon,
    output int      fail_count,
    output int      pending
);
    import lrsd_pkg::*;

    typedef enum logic [1:0] {AT_CHANNEL, AT_TYPE, AT_DATA} parse_state_t;

    typedef struct packed {
        logic                value_valid;
        logic [TAG_W-1:0]    tag;
        logic [INDEX_W-1:0]  tag_index;
        logic [RAW_W-1:0]    raw_value;
        logic [SCALE_W-1:0]  scale_code;
        logic [BYTE_W-1:0]   channel_number;
        logic                end_of_payload;
        logic [STATUS_W-1:0] end_status;
    } result_word_t;

    // parser state
    parse_state_t        phase;
    kind_info_t          rec;
    logic [LEN_W-1:0]    left;
    logic [BYTE_W-1:0]   hi_hold;
    logic [BYTE_W-1:0]   chan_hold;
    logic [INDEX_W-1:0]  tag_count [4];
    logic                halted;

    result_word_t        expected_words [$];
    int                  mismatches = 0;
    int                  waiting = 0;

    assign fail_count = mismatches;
    assign pending    = waiting;

    // what a type byte announces
    function automatic kind_info_t describe_type(input logic [BYTE_W-1:0] b);
        kind_info_t d;
        d = '0;
        d.known = 1'b1;
        case (b)
            TYPE_DIGITAL:
            begin
                d.emits = 1'b1; d.tag = TAG_OTHER; d.scale = SCALE_DIV1; d.len = LEN_BYTE;
            end
            TYPE_ANALOG:
            begin
                d.emits = 1'b1; d.is_signed = 1'b1; d.tag = TAG_DEFL;
                d.scale = SCALE_DIV100; d.len = LEN_WORD;
            end
            TYPE_LUMINOSITY:
            begin
                d.emits = 1'b1; d.tag = TAG_OTHER; d.scale = SCALE_DIV1; d.len = LEN_WORD;
            end
            TYPE_TEMPERATURE:
            begin
                d.emits = 1'b1; d.is_signed = 1'b1; d.tag = TAG_TEMP;
                d.scale = SCALE_DIV10; d.len = LEN_WORD;
            end
            TYPE_HUMIDITY:
            begin
                d.emits = 1'b1; d.tag = TAG_OTHER; d.scale = SCALE_DIV2; d.len = LEN_BYTE;
            end
            TYPE_PRESSURE:
            begin
                d.emits = 1'b1; d.tag = TAG_PRESS; d.scale = SCALE_DIV10; d.len = LEN_WORD;
            end
            TYPE_GPS:   d.len = LEN_GPS;
            TYPE_ACCEL: d.len = LEN_ACCEL;
            default:    d.known = 1'b0;
        endcase
        return d;
    endfunction

    task automatic clear_parser();
        phase     = AT_CHANNEL;
        rec       = '0;
        left      = '0;
        hi_hold   = '0;
        chan_hold = '0;
        halted    = 1'b0;
        foreach (tag_count[i])
            tag_count[i] = '0;
    endtask

    // advance the parser by one byte word and queue the word it causes
    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic is_last);
        result_word_t w;
        logic [15:0]  v;
        w = '0;
        if (!halted)
        begin
            case (phase)
                AT_CHANNEL:
                begin
                    chan_hold = b;
                    phase     = AT_TYPE;
                end
                AT_TYPE:
                begin
                    rec = describe_type(b);
                    if (!rec.known)
                    begin
                        halted = 1'b1;
                        phase  = AT_CHANNEL;
                    end
                    else
                    begin
                        left  = rec.len;
                        phase = AT_DATA;
                    end
                end
                default:
                begin
                    if (left == LEN_WORD)
                        hi_hold = b;
                    if (left != 0)
                        left = left - 1'b1;
                    if (left == 0)
                    begin
                        phase = AT_CHANNEL;
                        if (rec.emits)
                        begin
                            v = (rec.len == LEN_WORD) ? {hi_hold, b} : {8'h00, b};
                            w.value_valid    = 1'b1;
                            w.tag            = rec.tag;
                            w.tag_index      = tag_count[rec.tag];
                            tag_count[rec.tag] = tag_count[rec.tag] + 1'b1;
                            w.raw_value      = {rec.is_signed & v[15], v};
                            w.scale_code     = rec.scale;
                            w.channel_number = chan_hold;
                        end
                    end
                end
            endcase
        end
        if (is_last)
        begin
            w.end_of_payload = 1'b1;
            if (halted)
                w.end_status = STATUS_UNKNOWN;
            else if (phase != AT_CHANNEL)
                w.end_status = STATUS_TRUNCATED;
            else
                w.end_status = STATUS_OK;
            clear_parser();
        end
        if (w.value_valid || is_last)
            expected_words.push_back(w);
    endtask

    task automatic report_mismatch(input string field, input logic [RAW_W-1:0] got,
                                   input logic [RAW_W-1:0] want);
        $display("%0t: mismatch on %s: got %h, want %h", $time, field, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string field, input logic [RAW_W-1:0] got,
                               input logic [RAW_W-1:0] want);
        if (got !== want)
            report_mismatch(field, got, want);
    endtask

    // compare one accepted result word with the oldest expected word
    task automatic compare_word();
        result_word_t w;
        if (expected_words.size() == 0)
        begin
            report_mismatch("unexpected result word", result_mon.tag_index, '0);
        end
        else
        begin
            w = expected_words.pop_front();
            check_field("value_valid", result_mon.value_valid, w.value_valid);
            check_field("tag", result_mon.tag, w.tag);
            check_field("tag_index", result_mon.tag_index, w.tag_index);
            check_field("raw_value", result_mon.raw_value, w.raw_value);
            check_field("scale_code", result_mon.scale_code, w.scale_code);
            check_field("channel_number", result_mon.channel_number, w.channel_number);
            check_field("end_of_payload", result_mon.end_of_payload, w.end_of_payload);
            check_field("end_status", result_mon.end_status, w.end_status);
        end
    endtask

    // results come out in the cycle after their byte, so compare before predicting
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parser();
            expected_words.delete();
            waiting = 0;
        end
        else
        begin
            if (result_mon.valid === 1'b1 && result_mon.ready === 1'b1)
                compare_word();
            if (byte_mon.valid === 1'b1 && byte_mon.ready === 1'b1)
                decode_byte(byte_mon.data_byte, byte_mon.last_byte);
            waiting = expected_words.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: top level test of the LPP record stream decoder
// Sends directed and random payloads (well-formed, truncated, unknown type,
// noise, one long enough to wrap a tag index) with random idling on both
// channels and one long output stall, and gives the verdict of the checker.
// ----------------------------------------------------------------------------
module testbench;
    import lrsd_pkg::*;

    localparam logic [BYTE_W-1:0] KNOWN_TYPES [8] = '{
        TYPE_DIGITAL, TYPE_ANALOG, TYPE_LUMINOSITY, TYPE_TEMPERATURE,
        TYPE_HUMIDITY, TYPE_ACCEL, TYPE_PRESSURE, TYPE_GPS
    };
    localparam logic [BYTE_W-1:0] MISC_TYPES [3] = '{
        TYPE_DIGITAL, TYPE_LUMINOSITY, TYPE_HUMIDITY
    };
    localparam int RANDOM_BYTES  = 1050;
    localparam int HOLD_CYCLES   = 80;
    localparam int DRAIN_CYCLES  = 4;

    logic clk;
    logic rst_n;
    bit   steady;
    bit   hold_req;
    int   sent;
    int   fail_count;
    int   pending;

    logic [BYTE_W-1:0] payload [$];

    lrsd_byte_if   byte_ch ();
    lrsd_result_if result_ch ();

    lpp_record_stream_decoder_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_ch),
        .result_ch (result_ch)
    );

    lrsd_decode_checker decode_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_mon   (byte_ch),
        .result_mon (result_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int data_len(input logic [BYTE_W-1:0] ty);
        case (ty)
            TYPE_DIGITAL, TYPE_HUMIDITY: return int'(LEN_BYTE);
            TYPE_GPS:                    return int'(LEN_GPS);
            TYPE_ACCEL:                  return int'(LEN_ACCEL);
            default:                     return int'(LEN_WORD);
        endcase
    endfunction

    function automatic bit is_known(input logic [BYTE_W-1:0] ty);
        foreach (KNOWN_TYPES[i])
            if (KNOWN_TYPES[i] == ty)
                return 1'b1;
        return 1'b0;
    endfunction

    // favor the sign and range edges of a data word
    function automatic logic [15:0] pick_word();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    task automatic add_record(input logic [BYTE_W-1:0] ch, input logic [BYTE_W-1:0] ty,
                              input logic [15:0] word);
        int n;
        n = data_len(ty);
        payload.push_back(ch);
        payload.push_back(ty);
        if (n == 1)
        begin
            payload.push_back(word[7:0]);
        end
        else if (n == 2)
        begin
            payload.push_back(word[15:8]);
            payload.push_back(word[7:0]);
        end
        else
        begin
            repeat (n)
                payload.push_back(8'($urandom_range(255)));
        end
    endtask

    task automatic add_random_record();
        add_record(8'($urandom_range(255)), KNOWN_TYPES[$urandom_range(7)], pick_word());
    endtask

    task automatic add_unknown_type();
        logic [BYTE_W-1:0] ty;
        do
            ty = 8'($urandom_range(255));
        while (is_known(ty));
        payload.push_back(8'($urandom_range(255)));
        payload.push_back(ty);
    endtask

    // offer one byte word, with random idle cycles ahead of it
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic is_last);
        while (!steady && $urandom_range(99) < 22)
        begin
            byte_ch.valid <= 1'b0;
            @(negedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last_byte <= is_last;
        @(posedge clk);
        while (byte_ch.ready !== 1'b1)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic send_payload();
        foreach (payload[i])
            send_byte(payload[i], i == payload.size() - 1);
        payload.delete();
    endtask

    // receiver: random idling, none while steady, one long hold-off
    initial
    begin
        bit hold_done;
        hold_done       = 1'b0;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1)
                    @(negedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                result_ch.ready <= steady || ($urandom_range(99) >= 22);
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        int  kind;
        int  n;
        bit  wrap_done;
        rst_n             = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.last_byte = 1'b0;
        steady            = 1'b0;
        hold_req          = 1'b0;
        wrap_done         = 1'b0;
        sent              = 0;
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // signed and unsigned extremes, value on the last byte
        add_record(8'h00, TYPE_TEMPERATURE, 16'h8000);
        add_record(8'hFF, TYPE_ANALOG, 16'h7FFF);
        add_record(8'h81, TYPE_PRESSURE, 16'hFFFF);
        add_record(8'h7E, TYPE_HUMIDITY, 16'h00FF);
        send_payload();
        // unknown type as the last byte
        add_record(8'h55, TYPE_DIGITAL, 16'h0000);
        payload.push_back(8'hAA);
        payload.push_back(8'hFF);
        send_payload();
        // truncated: type missing, then data missing
        payload.push_back(8'h01);
        send_payload();
        add_record(8'h02, TYPE_TEMPERATURE, 16'h1234);
        void'(payload.pop_back());
        send_payload();

        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            steady = (sent >= 100 && sent < 250);
            if (sent >= 130)
                hold_req = 1'b1;
            if (sent >= 200 && !wrap_done)
            begin
                // enough misc values in one payload to wrap the tag index
                repeat (258)
                    add_record(8'($urandom_range(255)), MISC_TYPES[$urandom_range(2)],
                               pick_word());
                send_payload();
                wrap_done = 1'b1;
            end
            kind = $urandom_range(99);
            if (kind < 60)
            begin
                repeat ($urandom_range(1, 6))
                    add_random_record();
            end
            else if (kind < 75)
            begin
                repeat ($urandom_range(0, 3))
                    add_random_record();
                n = payload.size();
                add_random_record();
                repeat ($urandom_range(1, payload.size() - n - 1))
                    void'(payload.pop_back());
            end
            else if (kind < 90)
            begin
                repeat ($urandom_range(0, 3))
                    add_random_record();
                add_unknown_type();
                repeat ($urandom_range(0, 4))
                    payload.push_back(8'($urandom_range(255)));
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                    payload.push_back(8'($urandom_range(255)));
            end
            send_payload();
        end
        byte_ch.valid <= 1'b0;
        steady = 1'b0;

        // drain the remaining results
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // give up on a hung run
    initial
    begin
        #2400000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/lrsd_pkg.sv
rtl/core/lrsd_byte_if.sv
rtl/core/lrsd_result_if.sv
rtl/core/lrsd_type_decode.sv
rtl/core/lpp_record_stream_decoder_core.sv
test/lrsd_decode_checker.sv
test/testbench.sv
